[rtl/jbd_pkg.sv]
// jbd_pkg: types and constants shared by the jp2 box deframer
// parse phases, result roles, the result struct and header field sizes
// no dependencies

package jbd_pkg;

   typedef enum logic [1:0] {
      PH_LEN  = 2'd0,
      PH_TYPE = 2'd1,
      PH_XLEN = 2'd2,
      PH_BODY = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ROLE_HDR   = 3'd0,
      ROLE_BODY  = 3'd1,
      ROLE_LAST  = 3'd2,
      ROLE_EMPTY = 3'd3,
      ROLE_ERR   = 3'd4,
      ROLE_STOP  = 3'd5
   } role_type;

   typedef struct packed {
      role_type    role;
      logic [7:0]  payload_byte;
      logic [31:0] box_type;
      logic [63:0] box_length;
   } result_type;

   // count value on the last byte of each header field
   localparam logic [3:0]  LEN_LAST_COUNT  = 4'd3;
   localparam logic [3:0]  TYPE_LAST_COUNT = 4'd3;
   localparam logic [3:0]  XLEN_LAST_COUNT = 4'd7;

   localparam logic [63:0] BASIC_HDR_SIZE  = 64'd8;
   localparam logic [63:0] EXT_HDR_SIZE    = 64'd16;
   localparam logic [63:0] EXT_LEN_MARK    = 64'd1;

endpackage

[rtl/jbd_if.sv]
// jbd_req_if and jbd_rsp_if: valid/ready channels of the jp2 box deframer
// request carries one stream byte, response carries one tagged result
// no dependencies

interface jbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface jbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  role;
   logic [7:0]  payload_byte;
   logic [31:0] box_type;
   logic [63:0] box_length;

   modport source (output valid, output role, output payload_byte, output box_type,
                   output box_length, input ready);
   modport sink   (input valid, input role, input payload_byte, input box_type,
                   input box_length, output ready);
endinterface

[rtl/jp2_box_deframer_core.sv]
// jp2_box_deframer_core: splits a byte stream into jp2 boxes, one result per byte
// response valid is registered, raised in the cycle after the request transaction
// throughput 1 byte per cycle while rsp ready, one parser state update per byte
// synchronous active-high reset clears parser state and the response valid flag
// depends on jbd_pkg, jbd_if, jbd_parser and jbd_out_stage

module jp2_box_deframer_core (
   input  logic      clock,
   input  logic      reset,
   jbd_req_if.sink   req_chan,
   jbd_rsp_if.source rsp_chan
);

   jbd_pkg::result_type result;
   logic                space;
   logic                accept;

   assign req_chan.ready = space;
   assign accept         = req_chan.valid && space;

   jbd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (accept),
      .data_byte (req_chan.data_byte),
      .result    (result)
   );

   jbd_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .result   (result),
      .space    (space),
      .rsp_chan (rsp_chan)
   );

endmodule

[rtl/jbd_parser.sv]
// jbd_parser: box header state machine, one stream byte per accepted transaction
// holds phase, field counter, length, type and remaining content count
// depends on jbd_pkg

module jbd_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  logic [7:0]         data_byte,
   output jbd_pkg::result_type result
);

   jbd_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic [63:0] length_ff, length_in;
   logic [31:0] type_ff, type_in;
   logic [63:0] remaining_ff, remaining_in;
   logic        stopped_ff, stopped_in;

   logic [63:0] len_short_new;
   logic [63:0] len_ext_new;
   logic [31:0] type_new;
   logic [63:0] rem_basic;
   logic [63:0] rem_ext;
   logic [63:0] rem_body;
   logic [3:0]  count_inc;
   logic        short_is_err;

   assign len_short_new = (count_ff == 4'd0) ? {56'd0, data_byte}
                                             : {32'd0, length_ff[23:0], data_byte};
   assign len_ext_new   = {length_ff[55:0], data_byte};
   assign type_new      = {type_ff[23:0], data_byte};
   assign rem_basic     = length_ff - jbd_pkg::BASIC_HDR_SIZE;
   assign rem_ext       = len_ext_new - jbd_pkg::EXT_HDR_SIZE;
   assign rem_body      = remaining_ff - 64'd1;
   assign count_inc     = count_ff + 4'd1;
   assign short_is_err  = (len_short_new != jbd_pkg::EXT_LEN_MARK) &&
                          (len_short_new < jbd_pkg::BASIC_HDR_SIZE);

   // next state
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      length_in    = length_ff;
      type_in      = type_ff;
      remaining_in = remaining_ff;
      stopped_in   = stopped_ff;
      if (!stopped_ff) begin
         unique case (phase_ff)
            jbd_pkg::PH_LEN: begin
               length_in = len_short_new;
               count_in  = count_inc;
               if (count_ff == jbd_pkg::LEN_LAST_COUNT) begin
                  if (len_short_new == 64'd0 || short_is_err) begin
                     stopped_in = 1'b1;
                  end else begin
                     phase_in = jbd_pkg::PH_TYPE;
                     count_in = 4'd0;
                  end
               end
            end
            jbd_pkg::PH_TYPE: begin
               type_in  = type_new;
               count_in = count_inc;
               if (count_ff == jbd_pkg::TYPE_LAST_COUNT) begin
                  count_in = 4'd0;
                  if (length_ff == jbd_pkg::EXT_LEN_MARK) begin
                     phase_in  = jbd_pkg::PH_XLEN;
                     length_in = 64'd0;
                  end else begin
                     remaining_in = rem_basic;
                     phase_in     = (rem_basic == 64'd0) ? jbd_pkg::PH_LEN : jbd_pkg::PH_BODY;
                  end
               end
            end
            jbd_pkg::PH_XLEN: begin
               length_in = len_ext_new;
               count_in  = count_inc;
               if (count_ff == jbd_pkg::XLEN_LAST_COUNT) begin
                  if (len_ext_new < jbd_pkg::EXT_HDR_SIZE) begin
                     stopped_in = 1'b1;
                  end else begin
                     count_in     = 4'd0;
                     remaining_in = rem_ext;
                     phase_in     = (rem_ext == 64'd0) ? jbd_pkg::PH_LEN : jbd_pkg::PH_BODY;
                  end
               end
            end
            jbd_pkg::PH_BODY: begin
               remaining_in = rem_body;
               if (rem_body == 64'd0) begin
                  phase_in = jbd_pkg::PH_LEN;
                  count_in = 4'd0;
               end
            end
            default: begin
               phase_in = jbd_pkg::PH_LEN;
            end
         endcase
      end
   end

   // result for the byte being taken
   always_comb begin
      result.role         = jbd_pkg::ROLE_HDR;
      result.payload_byte = data_byte;
      result.box_type     = 32'd0;
      result.box_length   = 64'd0;
      if (stopped_ff) begin
         result.role = jbd_pkg::ROLE_STOP;
      end else begin
         unique case (phase_ff)
            jbd_pkg::PH_LEN: begin
               if (count_ff == jbd_pkg::LEN_LAST_COUNT) begin
                  if (len_short_new == 64'd0) begin
                     result.role = jbd_pkg::ROLE_STOP;
                  end else if (short_is_err) begin
                     result.role       = jbd_pkg::ROLE_ERR;
                     result.box_length = len_short_new;
                  end
               end
            end
            jbd_pkg::PH_TYPE: begin
               if (count_ff == jbd_pkg::TYPE_LAST_COUNT &&
                   length_ff != jbd_pkg::EXT_LEN_MARK && rem_basic == 64'd0) begin
                  result.role       = jbd_pkg::ROLE_EMPTY;
                  result.box_type   = type_new;
                  result.box_length = length_ff;
               end
            end
            jbd_pkg::PH_XLEN: begin
               if (count_ff == jbd_pkg::XLEN_LAST_COUNT) begin
                  if (len_ext_new < jbd_pkg::EXT_HDR_SIZE) begin
                     result.role       = jbd_pkg::ROLE_ERR;
                     result.box_type   = type_ff;
                     result.box_length = len_ext_new;
                  end else if (rem_ext == 64'd0) begin
                     result.role       = jbd_pkg::ROLE_EMPTY;
                     result.box_type   = type_ff;
                     result.box_length = len_ext_new;
                  end
               end
            end
            jbd_pkg::PH_BODY: begin
               result.role       = (rem_body == 64'd0) ? jbd_pkg::ROLE_LAST
                                                       : jbd_pkg::ROLE_BODY;
               result.box_type   = type_ff;
               result.box_length = length_ff;
            end
            default: begin
               result.role = jbd_pkg::ROLE_HDR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= jbd_pkg::PH_LEN;
         count_ff     <= 4'd0;
         length_ff    <= 64'd0;
         type_ff      <= 32'd0;
         remaining_ff <= 64'd0;
         stopped_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         length_ff    <= length_in;
         type_ff      <= type_in;
         remaining_ff <= remaining_in;
         stopped_ff   <= stopped_in;
      end
   end

endmodule

[rtl/jbd_out_stage.sv]
// jbd_out_stage: result register in front of the response channel
// loads a result on every accepted request, holds it while the sink stalls
// depends on jbd_pkg and jbd_rsp_if

module jbd_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  jbd_pkg::result_type result,
   output logic                space,
   jbd_rsp_if.source           rsp_chan
);

   logic                valid_ff, valid_in;
   jbd_pkg::result_type result_ff;

   assign space    = !valid_ff || rsp_chan.ready;
   assign valid_in = load || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.role         = result_ff.role;
   assign rsp_chan.payload_byte = result_ff.payload_byte;
   assign rsp_chan.box_type     = result_ff.box_type;
   assign rsp_chan.box_length   = result_ff.box_length;

endmodule

[tb/jp2_box_deframer_core_tb.sv]
// jp2_box_deframer_core_tb: self-checking testbench for the jp2 box deframer
// feeds box streams through a bursty driver and checks each tagged result
// depends on jbd_pkg, jbd_req_if, jbd_rsp_if and jp2_box_deframer_core

module jp2_box_deframer_core_tb;

   typedef struct packed {
      logic       drain;
      logic [7:0] data;
   } feed_item_type;

   logic clock;
   logic reset;

   jbd_req_if req_chan ();
   jbd_rsp_if rsp_chan ();

   jp2_box_deframer_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   feed_item_type       feed_q[$];
   jbd_pkg::result_type expected_results[$];
   int                  err_count = 0;
   logic                drain_next = 1'b0;
   logic                byte_taken = 1'b0;
   logic                hold_off = 1'b0;
   int                  cycle_count = 0;
   int                  burst_left = 0;
   int                  gap_left = 0;
   int                  stall_mode = 0;
   int                  mode_left = 0;

   // parser state of the predictor
   jbd_pkg::phase_type parse_phase;
   logic [3:0]         hdr_count;
   logic [63:0]        len_acc;
   logic [31:0]        type_acc;
   logic [63:0]        body_left;
   logic               halted;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data_byte = 8'd0;
      rsp_chan.ready = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #400000;
      $display("** jp2_box_deframer_core: FAILED **");
      $finish;
   end

   function automatic jbd_pkg::result_type open_content(
      input jbd_pkg::result_type r_in,
      input logic [63:0]         hdr_size
   );
      jbd_pkg::result_type r;
      r = r_in;
      body_left = len_acc - hdr_size;
      hdr_count = 4'd0;
      if (body_left == 64'd0) begin
         parse_phase = jbd_pkg::PH_LEN;
         r.role = jbd_pkg::ROLE_EMPTY;
         r.box_type = type_acc;
         r.box_length = len_acc;
      end else begin
         parse_phase = jbd_pkg::PH_BODY;
      end
      return r;
   endfunction

   function automatic jbd_pkg::result_type deframe_byte(input logic [7:0] b);
      jbd_pkg::result_type r;
      r.role = jbd_pkg::ROLE_HDR;
      r.payload_byte = b;
      r.box_type = 32'd0;
      r.box_length = 64'd0;
      if (halted) begin
         r.role = jbd_pkg::ROLE_STOP;
      end else begin
         case (parse_phase)
            jbd_pkg::PH_TYPE: begin
               type_acc = {type_acc[23:0], b};
               if (hdr_count == jbd_pkg::TYPE_LAST_COUNT) begin
                  if (len_acc == jbd_pkg::EXT_LEN_MARK) begin
                     parse_phase = jbd_pkg::PH_XLEN;
                     hdr_count = 4'd0;
                     len_acc = 64'd0;
                  end else begin
                     r = open_content(r, jbd_pkg::BASIC_HDR_SIZE);
                  end
               end else begin
                  hdr_count++;
               end
            end
            jbd_pkg::PH_XLEN: begin
               len_acc = {len_acc[55:0], b};
               if (hdr_count == jbd_pkg::XLEN_LAST_COUNT) begin
                  if (len_acc < jbd_pkg::EXT_HDR_SIZE) begin
                     halted = 1'b1;
                     r.role = jbd_pkg::ROLE_ERR;
                     r.box_type = type_acc;
                     r.box_length = len_acc;
                  end else begin
                     r = open_content(r, jbd_pkg::EXT_HDR_SIZE);
                  end
               end else begin
                  hdr_count++;
               end
            end
            jbd_pkg::PH_BODY: begin
               body_left--;
               r.role = jbd_pkg::ROLE_BODY;
               r.box_type = type_acc;
               r.box_length = len_acc;
               if (body_left == 64'd0) begin
                  parse_phase = jbd_pkg::PH_LEN;
                  hdr_count = 4'd0;
                  r.role = jbd_pkg::ROLE_LAST;
               end
            end
            default: begin
               if (hdr_count == 4'd0)
                  len_acc = 64'd0;
               len_acc = {32'd0, len_acc[23:0], b};
               if (hdr_count == jbd_pkg::LEN_LAST_COUNT) begin
                  hdr_count = 4'd0;
                  if (len_acc == 64'd0) begin
                     halted = 1'b1;
                     r.role = jbd_pkg::ROLE_STOP;
                  end else if (len_acc != jbd_pkg::EXT_LEN_MARK &&
                               len_acc < jbd_pkg::BASIC_HDR_SIZE) begin
                     halted = 1'b1;
                     r.role = jbd_pkg::ROLE_ERR;
                     r.box_length = len_acc;
                  end else begin
                     parse_phase = jbd_pkg::PH_TYPE;
                  end
               end else begin
                  hdr_count++;
               end
            end
         endcase
      end
      return r;
   endfunction

   task automatic push_byte(input logic [7:0] b);
      feed_q.push_back({drain_next, b});
      drain_next = 1'b0;
   endtask

   task automatic add_box(input logic [63:0] total, input logic ext,
                          input logic [31:0] kind, input int body_bytes);
      logic [31:0] lbox;
      lbox = ext ? 32'd1 : total[31:0];
      for (int i = 3; i >= 0; i--)
         push_byte(lbox[8*i +: 8]);
      for (int i = 3; i >= 0; i--)
         push_byte(kind[8*i +: 8]);
      if (ext)
         for (int i = 7; i >= 0; i--)
            push_byte(total[8*i +: 8]);
      repeat (body_bytes)
         push_byte(8'($urandom_range(0, 255)));
   endtask

   initial begin
      logic        ext;
      logic [63:0] total;
      logic [63:0] hdr_size;
      logic        second_drain;
      int          ending;

      second_drain = 1'b0;

      // empty box, one-byte box, empty extended box
      add_box(64'd8, 1'b0, 32'h0000_0000, 0);
      add_box(64'd9, 1'b0, 32'hFFFF_FFFF, 1);
      add_box(64'd16, 1'b1, 32'h6A70_3263, 0);

      drain_next = 1'b1;
      while (feed_q.size() < 700) begin
         if (!second_drain && feed_q.size() > 420) begin
            drain_next = 1'b1;
            second_drain = 1'b1;
         end
         ext = ($urandom_range(0, 3) == 0);
         hdr_size = ext ? jbd_pkg::EXT_HDR_SIZE : jbd_pkg::BASIC_HDR_SIZE;
         total = 64'($urandom_range(0, 24)) + hdr_size;
         add_box(total, ext, $urandom, int'(total - hdr_size));
      end

      // only one way of stopping per run, as reset comes only once
      ending = $urandom_range(0, 4);
      case (ending)
         0: add_box(64'd0, 1'b0, $urandom, 0);
         1: add_box(64'($urandom_range(2, 7)), 1'b0, $urandom, 0);
         2: add_box(64'($urandom_range(0, 15)), 1'b1, $urandom, 0);
         3: add_box({1'b1, 31'($urandom), 32'($urandom)}, 1'b1, $urandom, 24);
         default: add_box({32'd0, 1'b1, 31'($urandom)}, 1'b0, $urandom, 24);
      endcase
      repeat (8)
         push_byte(8'($urandom_range(0, 255)));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (feed_q.size() != 0)
         @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (err_count == 0)
         $display("** jp2_box_deframer_core: PASSED **");
      else
         $display("** jp2_box_deframer_core: FAILED **");
      $finish;
   end

   // long receiver hold-off while the sender keeps going
   always @(posedge clock) begin
      if (reset) begin
         cycle_count = 0;
         hold_off = 1'b0;
      end else begin
         cycle_count++;
         hold_off = (cycle_count >= 300 && cycle_count < 600);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (req_chan.valid && !byte_taken) begin
         req_chan.valid <= 1'b1;
      end else if (feed_q.size() == 0 ||
                   (feed_q[0].drain && expected_results.size() != 0)) begin
         req_chan.valid <= 1'b0;
      end else if (gap_left != 0 && !hold_off) begin
         gap_left--;
         req_chan.valid <= 1'b0;
      end else begin
         req_chan.valid <= 1'b1;
         req_chan.data_byte <= feed_q[0].data;
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 96);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_chan.ready <= !hold_off;
            1: rsp_chan.ready <= !hold_off && ($urandom_range(0, 1) == 1);
            2: rsp_chan.ready <= !hold_off && ($urandom_range(0, 3) == 0);
            default: rsp_chan.ready <= !hold_off && (mode_left % 3 == 0);
         endcase
      end
   end

   always @(posedge clock) begin : result_check
      jbd_pkg::result_type want;
      if (reset) begin
         byte_taken = 1'b0;
         parse_phase = jbd_pkg::PH_LEN;
         hdr_count = 4'd0;
         len_acc = 64'd0;
         type_acc = 32'd0;
         body_left = 64'd0;
         halted = 1'b0;
      end else begin
         byte_taken = req_chan.valid && req_chan.ready;
         if (byte_taken) begin
            expected_results.push_back(deframe_byte(req_chan.data_byte));
            void'(feed_q.pop_front());
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               err_count++;
               $display("%0t unexpected result transaction: role %0d byte %h", $time,
                        rsp_chan.role, rsp_chan.payload_byte);
            end else begin
               want = expected_results.pop_front();
               if (rsp_chan.role !== want.role) begin
                  err_count++;
                  $display("%0t role: expected %0d, got %0d", $time, want.role,
                           rsp_chan.role);
               end
               if (rsp_chan.payload_byte !== want.payload_byte) begin
                  err_count++;
                  $display("%0t payload_byte: expected %h, got %h", $time,
                           want.payload_byte, rsp_chan.payload_byte);
               end
               if (rsp_chan.box_type !== want.box_type) begin
                  err_count++;
                  $display("%0t box_type: expected %h, got %h", $time, want.box_type,
                           rsp_chan.box_type);
               end
               if (rsp_chan.box_length !== want.box_length) begin
                  err_count++;
                  $display("%0t box_length: expected %h, got %h", $time,
                           want.box_length, rsp_chan.box_length);
               end
            end
         end
      end
   end

endmodule

[files.f]
rtl/jbd_pkg.sv
rtl/jbd_if.sv
rtl/jbd_parser.sv
rtl/jbd_out_stage.sv
rtl/jp2_box_deframer_core.sv
tb/jp2_box_deframer_core_tb.sv
